// File: sv/index_range_set_table_unit_defines.svh
// Assertion macros for the index range set table unit.
`ifndef INDEX_RANGE_SET_TABLE_UNIT_DEFINES_SVH
`define INDEX_RANGE_SET_TABLE_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define IRST_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IRST_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/irst_pkg.sv
// Shared types, constants and codes of the index range set table unit.
package irst_pkg;

   localparam int MAX_RANGES = 128;
   localparam int INDEX_BITS = 16;
   localparam int BOUND_BITS = INDEX_BITS + 1;
   localparam int ADDR_BITS  = $clog2(MAX_RANGES);
   localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_EXTEND = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_QUERY  = 3'd4
   } irst_op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_NOLAST = 2'd2
   } irst_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_APPEND,
      ST_TAIL,
      ST_FINISH
   } irst_state_type;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [INDEX_BITS-1:0] item_index;
   } irst_req_type;

   typedef struct packed {
      logic            is_member;
      irst_status_type status;
   } irst_rsp_type;

   // One table entry; start and stop are one bit wider than an index so an empty tail [2^N, 2^N) stays empty.
   typedef struct packed {
      logic                  valid;
      logic [BOUND_BITS-1:0] start;
      logic [BOUND_BITS-1:0] stop;
   } irst_entry_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      irst_entry_type       entry;
   } irst_wr_type;

   typedef struct packed {
      logic covers;
      logic at_start;
      logic single;
      logic above_start;
   } irst_cmp_type;

   typedef struct packed {
      logic                busy;
      logic [CNT_BITS-1:0] used;
   } irst_mon_type;

endpackage

// File: sv/index_range_set_table_unit.sv
// Index range set table unit: top level.
// Sequence: clear and unknown requests go straight to finish; extend reads and evaluates
//   the last entry (if any); add, remove and query read and evaluate each scanned entry,
//   append or split where needed, then finish, waiting for a free output register.
// Throughput: one request at a time; the range memory and its compare unit are visited
//   once per entry, so the scan loop sets the rate.
// Reset: synchronous, active high; empties the table and drops any pending response.
`include "index_range_set_table_unit_defines.svh"

module index_range_set_table_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  irst_pkg::irst_req_type   req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output irst_pkg::irst_rsp_type   rsp_data
);
   import irst_pkg::*;

   // Memory read and write paths between sequencer and storage.
   logic                   rd_en;
   logic [ADDR_BITS-1:0]   rd_addr;
   irst_entry_type         rd_entry;
   irst_wr_type            wr;

   // Compare unit operands and result.
   logic [INDEX_BITS-1:0]  cmp_index;
   irst_cmp_type           cmp;

   // Occupancy and busy flag, observed by the checks below.
   irst_mon_type           mon;

   // Handshake terms used by the checks.
   logic                   req_fire;
   logic                   clear_fire;
   logic                   idle_empty;

   // The sequencer owns all control: it latches a request, walks the entries below
   // the fill count (read in one state, evaluate in the next), rewrites covering entries
   // (the last one on extend), appends new ranges at the fill count, and parks the
   // response in an output register so the next request can be accepted while it waits.
   irst_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_entry  (rd_entry),
      .wr        (wr),
      .cmp_index (cmp_index),
      .cmp       (cmp),
      .mon       (mon)
   );

   // Range storage; only entries below the fill count are ever read, so no clearing.
   irst_mem u_mem (
      .clock    (clock),
      .wr       (wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // One comparator block, reused for every entry of the scan.
   irst_cmp u_cmp (
      .entry  (rd_entry),
      .index  (cmp_index),
      .result (cmp)
   );

   assign req_fire   = req_valid && req_ready;
   assign clear_fire = req_fire && (req_data.req_type == OP_CLEAR);
   assign idle_empty = (mon.used == '0) && !rsp_valid && !mon.busy;

   // Fill count never runs past the table depth.
   `IRST_ASSERT(a_used_bound, mon.used <= CNT_BITS'(MAX_RANGES), "fill count exceeds table depth")
   // An accepted request always leaves idle, so ready drops on the next cycle.
   `IRST_ASSERT(a_busy_after_req, req_fire |=> (!req_ready && mon.busy), "ready held after accept")
   // A clear empties the table at once.
   `IRST_ASSERT(a_clear_empties, clear_fire |=> (mon.used == '0), "clear left entries")
   // Reset empties the table and drops any response.
   `IRST_ASSERT_ALWAYS(a_reset_state, reset |=> idle_empty, "reset state wrong")

endmodule

// File: sv/irst_mem.sv
// Range table storage: one write port, one registered read port.
module irst_mem (
   input  logic                                clock,
   input  irst_pkg::irst_wr_type               wr,
   input  logic                                rd_en,
   input  logic [irst_pkg::ADDR_BITS-1:0]      rd_addr,
   output irst_pkg::irst_entry_type            rd_entry
);
   import irst_pkg::*;

   irst_entry_type mem_ff [MAX_RANGES];
   irst_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.entry;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: sv/irst_cmp.sv
// Shared compare unit: tests one table entry against the request index.
module irst_cmp (
   input  irst_pkg::irst_entry_type              entry,
   input  logic [irst_pkg::INDEX_BITS-1:0]       index,
   output irst_pkg::irst_cmp_type                result
);
   import irst_pkg::*;

   logic [BOUND_BITS-1:0] wide_idx;
   logic [BOUND_BITS-1:0] next_idx;

   assign wide_idx = {1'b0, index};
   assign next_idx = wide_idx + BOUND_BITS'(1);

   always_comb begin
      result.covers      = entry.valid && (entry.start <= wide_idx) && (entry.stop > wide_idx);
      result.at_start    = (entry.start == wide_idx);
      result.single      = (entry.stop == next_idx);
      result.above_start = (wide_idx > entry.start);
   end

endmodule

// File: sv/irst_seq.sv
// Sequencer: scans the table one entry at a time and applies each request.
module irst_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  irst_pkg::irst_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output irst_pkg::irst_rsp_type           rsp_data,
   output logic                             rd_en,
   output logic [irst_pkg::ADDR_BITS-1:0]   rd_addr,
   input  irst_pkg::irst_entry_type         rd_entry,
   output irst_pkg::irst_wr_type            wr,
   output logic [irst_pkg::INDEX_BITS-1:0]  cmp_index,
   input  irst_pkg::irst_cmp_type           cmp,
   output irst_pkg::irst_mon_type           mon
);
   import irst_pkg::*;

   irst_state_type         state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]    k_ff, k_in;
   logic [CNT_BITS-1:0]    limit_ff, limit_in;
   logic [CNT_BITS-1:0]    used_ff, used_in;
   irst_status_type        status_ff, status_in;
   logic                   member_ff, member_in;
   irst_rsp_type           rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS-1:0]    k_next;
   logic                   last_entry;
   logic                   table_full;
   logic                   rsp_free;
   logic [BOUND_BITS-1:0]  wide_idx;
   logic [BOUND_BITS-1:0]  next_idx;

   assign k_next     = k_ff + CNT_BITS'(1);
   assign last_entry = (k_next == limit_ff);
   assign table_full = (used_ff == CNT_BITS'(MAX_RANGES));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign wide_idx   = {1'b0, idx_ff};
   assign next_idx   = wide_idx + BOUND_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.req_type)
                  OP_ADD:                         state_in = (used_ff == '0) ? ST_APPEND : ST_READ;
                  OP_REMOVE, OP_EXTEND, OP_QUERY: state_in = (used_ff == '0) ? ST_FINISH : ST_READ;
                  default:                        state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            unique case (op_ff)
               OP_ADD: begin
                  if (cmp.covers)      state_in = ST_FINISH;
                  else if (last_entry) state_in = ST_APPEND;
                  else                 state_in = ST_READ;
               end
               OP_QUERY:  state_in = (cmp.covers || last_entry) ? ST_FINISH : ST_READ;
               OP_REMOVE: begin
                  if (cmp.covers && !cmp.at_start) state_in = ST_TAIL;
                  else if (last_entry)             state_in = ST_FINISH;
                  else                             state_in = ST_READ;
               end
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_APPEND: state_in = ST_FINISH;
         ST_TAIL:   state_in = (k_ff == limit_ff) ? ST_FINISH : ST_READ;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      limit_in     = limit_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      member_in    = member_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = k_ff[ADDR_BITS-1:0];
      wr           = '0;
      wr.addr      = used_ff[ADDR_BITS-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_data.req_type;
               idx_in    = req_data.item_index;
               limit_in  = used_ff;
               k_in      = '0;
               status_in = STATUS_OK;
               member_in = 1'b0;
               unique case (req_data.req_type)
                  OP_EXTEND: begin
                     if (used_ff == '0) status_in = STATUS_NOLAST;
                     else               k_in      = used_ff - CNT_BITS'(1);
                  end
                  OP_CLEAR: used_in = '0;
                  default: ;
               endcase
            end
         end
         ST_READ: rd_en = 1'b1;
         ST_EVAL: begin
            k_in = k_next;
            unique case (op_ff)
               OP_QUERY: member_in = cmp.covers;
               OP_REMOVE: begin
                  if (cmp.covers) begin
                     wr.en    = 1'b1;
                     wr.addr  = k_ff[ADDR_BITS-1:0];
                     wr.entry = rd_entry;
                     if (cmp.at_start) begin
                        if (cmp.single) wr.entry.valid = 1'b0;
                        else            wr.entry.start = next_idx;
                     end else begin
                        wr.entry.stop = wide_idx;
                     end
                  end
               end
               OP_EXTEND: begin
                  if (!rd_entry.valid) begin
                     status_in = STATUS_NOLAST;
                  end else begin
                     wr.en    = 1'b1;
                     wr.addr  = k_ff[ADDR_BITS-1:0];
                     wr.entry = rd_entry;
                     if (cmp.above_start) wr.entry.stop  = next_idx;
                     else                 wr.entry.start = wide_idx;
                  end
               end
               default: ;
            endcase
         end
         ST_APPEND, ST_TAIL: begin
            // Append [i, i+1) for add, or the split tail [i+1, old end) for remove.
            if (table_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr.en          = 1'b1;
               wr.entry.valid = 1'b1;
               wr.entry.start = (state_ff == ST_TAIL) ? next_idx : wide_idx;
               wr.entry.stop  = (state_ff == ST_TAIL) ? rd_entry.stop : next_idx;
               used_in        = used_ff + CNT_BITS'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_in.is_member = member_ff;
               rsp_in.status    = status_ff;
               rsp_valid_in     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      limit_ff  <= limit_in;
      status_ff <= status_in;
      member_ff <= member_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmp_index = idx_ff;
   assign mon.busy  = (state_ff != ST_IDLE);
   assign mon.used  = used_ff;

endmodule
